[hdl/vpd_pkg.sv]
// Package: widths, lead byte codes and shared types of the prefix varint decoder.
package vpd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned PendW  = 4;

  localparam logic [ByteW-1:0] MaskTop1  = 8'h80;
  localparam logic [ByteW-1:0] MaskTop2  = 8'hC0;
  localparam logic [ByteW-1:0] MaskTop4  = 8'hF0;
  localparam logic [ByteW-1:0] MaskTop6  = 8'hFC;
  localparam logic [ByteW-1:0] Lead1     = 8'h00;
  localparam logic [ByteW-1:0] Lead2     = 8'h80;
  localparam logic [ByteW-1:0] Lead4     = 8'hE0;
  localparam logic [ByteW-1:0] LeadMark  = 8'hF0;
  localparam logic [ByteW-1:0] Mark32    = 8'hF0;
  localparam logic [ByteW-1:0] Mark64    = 8'hF4;
  localparam logic [ByteW-1:0] MarkInv   = 8'hF8;
  localparam logic [ByteW-1:0] Bits7     = 8'h7F;
  localparam logic [ByteW-1:0] Bits6     = 8'h3F;
  localparam logic [ByteW-1:0] Bits5     = 8'h1F;
  localparam logic [ByteW-1:0] Bits4     = 8'h0F;
  localparam logic [ByteW-1:0] Bits2     = 8'h03;

  localparam logic [PendW-1:0] PendNone  = 4'd0;
  localparam logic [PendW-1:0] PendOne   = 4'd1;
  localparam logic [PendW-1:0] PendTwo   = 4'd2;
  localparam logic [PendW-1:0] PendThree = 4'd3;
  localparam logic [PendW-1:0] PendFour  = 4'd4;
  localparam logic [PendW-1:0] PendEight = 4'd8;

  typedef struct packed {
    logic [PendW-1:0]  pend;
    logic [ValueW-1:0] acc;
    logic              inv;
  } state_t;

  typedef struct packed {
    logic              emit;
    logic [ValueW-1:0] value;
    logic              short_error;
  } result_t;

  localparam state_t StateReset = '{pend: PendNone, acc: '0, inv: 1'b0};

endpackage

[hdl/vpd_in_if.sv]
// Interface: input byte channel of the prefix varint decoder.
interface vpd_in_if;
  import vpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

[hdl/vpd_out_if.sv]
// Interface: decoded value channel of the prefix varint decoder.
interface vpd_out_if;
  import vpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic              short_error;

  modport source (output valid, output value, output short_error, input ready);
  modport sink   (input valid, input value, input short_error, output ready);
endinterface

[hdl/varint_prefix_decoder_unit.sv]
// Top level: prefix-coded varint decoder, one stream byte per request.
// Takes one byte per cycle and gives a decoded 64-bit value from the byte that completes
// it: a byte is captured in an input register, then decoded against the running
// state, and a finished value goes into the result register. When results are not taken,
// the result register holds and one more byte waits in the input register; bytes that do
// not finish a value keep moving while a result waits. A stream_end request flushes a
// pending value with zero bytes and short_error set, and produces nothing when idle.
module varint_prefix_decoder_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  vpd_in_if.sink          in_i,
  vpd_out_if.source       out_o
);
  import vpd_pkg::*;

  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_end_q;
  state_t           st_q;
  state_t           st_d;
  result_t          step_res;
  logic             out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic             out_err_q;
  logic             out_free;
  logic             advance;

  vpd_step u_step (
    .state_i      (st_q),
    .in_byte_i    (s1_byte_q),
    .stream_end_i (s1_end_q),
    .state_o      (st_d),
    .result_o     (step_res)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = s1_valid_q && (!step_res.emit || out_free);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.in_byte;
      s1_end_q  <= in_i.stream_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && step_res.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_res.emit) begin
      out_value_q <= step_res.value;
      out_err_q   <= step_res.short_error;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.value       = out_value_q;
  assign out_o.short_error = out_err_q;

`ifndef ASSERT_OFF
  a_pend_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pend <= PendEight)
    else $error("bytes pending out of range");

  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_end_q |=> st_q.pend == PendNone && !st_q.inv)
    else $error("state not cleared after stream end");

  a_emit_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step_res.emit |=> out_o.valid && st_q.pend == PendNone)
    else $error("emitted value not registered or state kept");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.value))
    else $error("result register overwritten while stalled");
`endif

endmodule

[hdl/vpd_step.sv]
// Next-state and result logic for one byte of the prefix varint decoder.
module vpd_step (
  input  vpd_pkg::state_t          state_i,
  input  logic [vpd_pkg::ByteW-1:0] in_byte_i,
  input  logic                      stream_end_i,
  output vpd_pkg::state_t          state_o,
  output vpd_pkg::result_t         result_o
);
  import vpd_pkg::*;

  logic [ValueW-1:0] raw;
  logic [ValueW-1:0] acc_sh;
  logic              err;
  logic              done;
  logic [5:0]        shamt;
  state_t            nxt;

  assign acc_sh = {state_i.acc[ValueW-ByteW-1:0], in_byte_i};
  assign shamt  = {state_i.pend[2:0], 3'b000};

  always_comb begin
    nxt  = state_i;
    raw  = '0;
    err  = 1'b0;
    done = 1'b0;
    if (stream_end_i) begin
      if (state_i.pend != PendNone || state_i.inv) begin
        done = 1'b1;
        err  = 1'b1;
        raw  = (state_i.pend >= PendEight) ? '0 : (state_i.acc << shamt);
      end
    end else if (state_i.pend != PendNone) begin
      nxt.acc  = acc_sh;
      nxt.pend = state_i.pend - PendOne;
      if (state_i.pend == PendOne) begin
        done = 1'b1;
        raw  = acc_sh;
      end
    end else if ((in_byte_i & MaskTop1) == Lead1) begin
      done = 1'b1;
      raw  = {{(ValueW-ByteW){1'b0}}, in_byte_i & Bits7};
    end else if ((in_byte_i & MaskTop2) == Lead2) begin
      nxt.acc  = {{(ValueW-ByteW){1'b0}}, in_byte_i & Bits6};
      nxt.pend = PendOne;
    end else if ((in_byte_i & MaskTop4) == LeadMark) begin
      case (in_byte_i & MaskTop6)
        Mark32: begin
          nxt.acc  = '0;
          nxt.pend = PendFour;
        end
        Mark64: begin
          nxt.acc  = '0;
          nxt.pend = PendEight;
        end
        MarkInv: begin
          nxt.inv = ~state_i.inv;
        end
        default: begin
          done = 1'b1;
          raw  = ~{{(ValueW-ByteW){1'b0}}, in_byte_i & Bits2};
        end
      endcase
    end else if ((in_byte_i & MaskTop4) == Lead4) begin
      nxt.acc  = {{(ValueW-ByteW){1'b0}}, in_byte_i & Bits4};
      nxt.pend = PendThree;
    end else begin
      nxt.acc  = {{(ValueW-ByteW){1'b0}}, in_byte_i & Bits5};
      nxt.pend = PendTwo;
    end

    if (done) begin
      nxt = StateReset;
    end
  end

  assign state_o              = nxt;
  assign result_o.emit        = done;
  assign result_o.value       = state_i.inv ? ~raw : raw;
  assign result_o.short_error = err;

endmodule

[test/vpd_checker.sv]
// Checker: watches both channels, decodes the accepted bytes and compares the decoded values.
`timescale 1ns / 1ps
module vpd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  vpd_in_if           in_mon_i,
  vpd_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned expect_count_o
);
  import vpd_pkg::*;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              short_error;
  } decoded_t;

  decoded_t          decoded_q[$];
  decoded_t          oldest;
  logic [PendW-1:0]  owed;
  logic [ValueW-1:0] gathered;
  logic              flip;

  task automatic finish_value(input logic [ValueW-1:0] v, input logic err);
    decoded_q.push_back('{value: flip ? ~v : v, short_error: err});
    owed     = PendNone;
    gathered = '0;
    flip     = 1'b0;
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b, input logic fin);
    logic [ValueW-1:0] padded;
    if (fin) begin
      if (owed == PendNone && !flip) return;
      padded = (owed >= PendEight) ? '0 : gathered << (8 * owed);
      finish_value(padded, 1'b1);
      return;
    end
    if (owed != PendNone) begin
      gathered = {gathered[ValueW-ByteW-1:0], b};
      owed     = owed - 1'b1;
      if (owed == PendNone) finish_value(gathered, 1'b0);
      return;
    end
    if ((b & MaskTop1) == Lead1) begin
      finish_value(ValueW'(b & Bits7), 1'b0);
    end else if ((b & MaskTop2) == Lead2) begin
      gathered = ValueW'(b & Bits6);
      owed     = PendOne;
    end else if ((b & MaskTop4) == LeadMark) begin
      case (b & MaskTop6)
        Mark32: begin
          gathered = '0;
          owed     = PendFour;
        end
        Mark64: begin
          gathered = '0;
          owed     = PendEight;
        end
        MarkInv: begin
          flip = ~flip;
        end
        default: begin
          finish_value(~ValueW'(b & Bits2), 1'b0);
        end
      endcase
    end else if ((b & MaskTop4) == Lead4) begin
      gathered = ValueW'(b & Bits4);
      owed     = PendThree;
    end else begin
      gathered = ValueW'(b & Bits5);
      owed     = PendTwo;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed           = PendNone;
      gathered       = '0;
      flip           = 1'b0;
      decoded_q.delete();
      fail_count_o   = 0;
      expect_count_o = 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (decoded_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result: expected none, actual value %h short_error %b",
                   $time, out_mon_i.value, out_mon_i.short_error);
        end else begin
          oldest = decoded_q.pop_front();
          if (out_mon_i.value !== oldest.value) begin
            fail_count_o++;
            $display("%0t: value mismatch: expected %h, actual %h",
                     $time, oldest.value, out_mon_i.value);
          end
          if (out_mon_i.short_error !== oldest.short_error) begin
            fail_count_o++;
            $display("%0t: short_error mismatch: expected %b, actual %b",
                     $time, oldest.short_error, out_mon_i.short_error);
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) decode_byte(in_mon_i.in_byte, in_mon_i.stream_end);
      expect_count_o = decoded_q.size();
    end
  end

endmodule

[test/tb_top.sv]
// Testbench top: drives coded byte streams into the decoder, stalls results and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
  import vpd_pkg::*;

  localparam int unsigned ByteTarget = 1800;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned DrainWait  = 16;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  bit          steady = 1'b0;
  int unsigned sent   = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count;
  int unsigned expect_count;

  vpd_in_if  in_if ();
  vpd_out_if out_if ();

  varint_prefix_decoder_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  vpd_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon_i       (in_if),
    .out_mon_i      (out_if),
    .fail_count_o   (fail_count),
    .expect_count_o (expect_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic fin);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.stream_end <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
  endtask

  task automatic send_end();
    send_byte(ByteW'($urandom), 1'b1);
  endtask

  task automatic send_varint();
    logic [ByteW-1:0] r;
    logic [ByteW-1:0] lead;
    int unsigned      n;
    int unsigned      cut;
    bit               trunc;
    r = ByteW'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) send_end();
      else send_byte(r, 1'b0);
      return;
    end
    if ($urandom_range(0, 9) >= 7) begin
      repeat ($urandom_range(1, 3)) send_byte(MarkInv | (ByteW'($urandom) & Bits2), 1'b0);
    end
    case ($urandom_range(0, 8))
      0: begin lead = r & Bits7;              n = 0; end
      1: begin lead = Lead2 | (r & Bits6);    n = 1; end
      2: begin lead = MaskTop2 | (r & Bits5); n = 2; end
      3: begin lead = Lead4 | (r & Bits4);    n = 3; end
      4: begin lead = Mark32 | (r & Bits2);   n = 4; end
      5, 6: begin lead = Mark64 | (r & Bits2); n = 8; end
      default: begin lead = MaskTop6 | (r & Bits2); n = 0; end
    endcase
    trunc = ($urandom_range(0, 7) == 0);
    cut   = trunc ? $urandom_range(0, n) : n + 1;
    if (cut == 0 && n == 0 && $urandom_range(0, 1) == 0) begin
      send_end();
      return;
    end
    send_byte(lead, 1'b0);
    for (int unsigned i = 1; i <= n; i++) begin
      if (i == cut && n != 0) begin
        send_end();
        return;
      end
      case ($urandom_range(0, 9))
        0: send_byte('0, 1'b0);
        1: send_byte('1, 1'b0);
        default: send_byte(ByteW'($urandom), 1'b0);
      endcase
    end
  endtask

  initial begin
    int unsigned hold;
    hold         = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (steady) begin
        out_if.ready <= 1'b1;
      end else if (hold != 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        hold = pick_gap();
        if (hold != 0) begin
          out_if.ready <= 1'b0;
          hold--;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.in_byte    = '0;
    in_if.stream_end = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00, 1'b0);
    send_byte(Bits7, 1'b0);
    send_byte(Lead2 | Bits6, 1'b0);
    send_byte('1, 1'b0);
    send_byte(MaskTop2 | Bits5, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(Mark32 | 8'h01, 1'b0);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hEF, 1'b0);
    // stream end while idle
    send_end();
    send_byte(MarkInv, 1'b0);
    send_byte('1, 1'b0);
    // two inversion markers cancel
    send_byte(MarkInv | 8'h01, 1'b0);
    send_byte(MarkInv | 8'h02, 1'b0);
    send_byte(Bits7, 1'b0);
    send_byte(MaskTop6, 1'b0);
    // stream end in the middle of a 64-bit value
    send_byte(Mark64, 1'b0);
    send_byte(Lead2, 1'b0);
    send_end();
    // stream end after only an inversion marker
    send_byte(MarkInv | Bits2, 1'b0);
    send_end();
    send_byte(Lead4 | 8'h05, 1'b0);
    send_end();

    while (sent < ByteTarget) begin
      steady = ((sent / 300) % 4 == 3);
      send_varint();
    end
    steady = 1'b0;
    in_if.valid <= 1'b0;

    @(negedge clk_i);
    while (expect_count != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (fail_count == 0 && expect_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
